// ===== sv/bgs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, request codes and the logistic flip table of the Gibbs unit sampler.
package bgs_pkg;

    // Configuration defaults and fixed field widths
    localparam int DEFAULT_UNITS = 8;
    localparam int COEF_W        = 16;
    localparam int IDX_W         = 3;
    localparam int RAND_W        = 16;
    localparam int ITEMP_W       = 16;
    localparam int STATES_W      = 8;
    localparam int FRAC_BITS     = 12;
    localparam int TAB_IDX_W     = 6;
    localparam int PROB_W        = 17;
    localparam int MSAT_W        = 16;

    localparam logic [ITEMP_W-1:0] ITEMP_RESET = 16'd4096;
    // Scaled magnitude saturates at 8.0 in Q.12
    localparam logic [MSAT_W-1:0]  MAG_SAT     = 16'd32768;
    // Round to nearest quarter before the table index
    localparam logic [MSAT_W:0]    IDX_ROUND   = 17'd512;
    localparam logic [PROB_W-1:0]  PROB_HALF   = 17'd32768;
    localparam logic [PROB_W-1:0]  PROB_ONE    = 17'd65536;

    // Request codes
    typedef enum logic [1:0] {
        REQ_WEIGHT   = 2'd0,
        REQ_BIAS     = 2'd1,
        REQ_STATE    = 2'd2,
        REQ_RESAMPLE = 2'd3
    } req_type_t;

    // round(65536 / (1 + exp(k/4))) for k = 0..32
    function automatic logic [15:0] flip_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [15:0] p;
        unique case (idx)
            6'd0:    p = 16'd32768;
            6'd1:    p = 16'd28693;
            6'd2:    p = 16'd24743;
            6'd3:    p = 16'd21025;
            6'd4:    p = 16'd17625;
            6'd5:    p = 16'd14595;
            6'd6:    p = 16'd11955;
            6'd7:    p = 16'd9702;
            6'd8:    p = 16'd7812;
            6'd9:    p = 16'd6249;
            6'd10:   p = 16'd4971;
            6'd11:   p = 16'd3938;
            6'd12:   p = 16'd3108;
            6'd13:   p = 16'd2446;
            6'd14:   p = 16'd1921;
            6'd15:   p = 16'd1506;
            6'd16:   p = 16'd1179;
            6'd17:   p = 16'd922;
            6'd18:   p = 16'd720;
            6'd19:   p = 16'd562;
            6'd20:   p = 16'd439;
            6'd21:   p = 16'd342;
            6'd22:   p = 16'd267;
            6'd23:   p = 16'd208;
            6'd24:   p = 16'd162;
            6'd25:   p = 16'd126;
            6'd26:   p = 16'd98;
            6'd27:   p = 16'd77;
            6'd28:   p = 16'd60;
            6'd29:   p = 16'd47;
            6'd30:   p = 16'd36;
            6'd31:   p = 16'd28;
            default: p = 16'd22;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/bgs_coef_mem.sv =====
`timescale 1ns / 1ps
// Coefficient memory: weights off the diagonal, unit bias on the diagonal.
module bgs_coef_mem
    import bgs_pkg::*;
#(
    parameter int ADDR_W = 6,
    parameter int DATA_W = COEF_W
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/boltzmann_gibbs_unit_sampler_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Gibbs unit sampler: sequencer, field accumulator, flip decision.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid / in_stall  | req_type, unit_index, other_index, value,
//           |                      | random_fraction
//  output   | out_valid / out_stall| new_state, all_states
//  config   | cfg_valid / cfg_ready| cfg_data (inverse temperature, Q4.12)
//
//  After reset the coefficient memory is cleared, one entry per cycle, over all of
//  its entries; no request is taken meanwhile.
//  A resample request steps through S_EXEC, S_ACC, S_DRAIN, S_MUL, S_PROB, S_DECIDE
//  and S_DONE; in S_ACC the accumulator reads one weight per cycle from the single
//  memory read port. A weight write adds S_WR_PAIR for the mirrored entry unless
//  dropped for the diagonal or a bad index. One request is in flight at a time.
//  A held result in the output register keeps the next one waiting in S_DONE.

module boltzmann_gibbs_unit_sampler_unit
    import bgs_pkg::*;
#(
    parameter int UNITS = DEFAULT_UNITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               req_type,
    input  logic [IDX_W-1:0]         unit_index,
    input  logic [IDX_W-1:0]         other_index,
    input  logic signed [COEF_W-1:0] value,
    input  logic [RAND_W-1:0]        random_fraction,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     new_state,
    output logic [STATES_W-1:0]      all_states,
    // configuration channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ITEMP_W-1:0]       cfg_data
);

    localparam int UIDX_W  = (UNITS > 2) ? $clog2(UNITS) : 1;
    localparam int ADDR_W  = 2 * UIDX_W;
    localparam int FIELD_W = COEF_W + UIDX_W + 1;
    localparam int PROD_W  = FIELD_W + ITEMP_W;
    localparam int M_W     = PROD_W - FRAC_BITS;

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_EXEC    = 10'b0000000100,
        S_WR_PAIR = 10'b0000001000,
        S_ACC     = 10'b0000010000,
        S_DRAIN   = 10'b0000100000,
        S_MUL     = 10'b0001000000,
        S_PROB    = 10'b0010000000,
        S_DECIDE  = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          clr_reg;
    logic [UIDX_W-1:0]          col_reg;
    logic [UIDX_W-1:0]          rd_col_reg;
    logic                       rd_pend_reg;
    logic [UNITS-1:0]           states_reg, states_next;
    logic                       out_valid_reg;
    logic [ITEMP_W-1:0]         itemp_reg;

    // latched request
    req_type_t                  req_reg;
    logic [IDX_W-1:0]           u_reg;
    logic [IDX_W-1:0]           o_reg;
    logic [COEF_W-1:0]          val_reg;
    logic [RAND_W-1:0]          rnd_reg;

    // datapath
    logic signed [FIELD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       de_pos_reg;
    logic                       de_zero_reg;
    logic [PROB_W-1:0]          p_reg;
    logic                       new_state_reg;
    logic [STATES_W-1:0]        all_states_reg;

    logic                       accept;
    logic                       u_ok, o_ok;
    logic [UIDX_W-1:0]          uidx, oidx;
    logic                       cur;
    logic                       out_load;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [COEF_W-1:0]          mem_wdata;
    logic [COEF_W-1:0]          mem_rdata;
    logic                       add_en;
    logic                       acc_neg;
    logic [FIELD_W-1:0]         mag;
    logic [M_W-1:0]             m_val;
    logic [MSAT_W-1:0]          m_sat;
    logic [MSAT_W:0]            m_round;
    logic [TAB_IDX_W-1:0]       tab_idx;
    logic [PROB_W-1:0]          entry;
    logic [PROB_W-1:0]          p_val;
    logic                       flip;
    logic [UNITS+STATES_W-1:0]  states_pad;

    // Handshakes
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Index decode of the latched request
    assign u_ok = (32'(u_reg) < 32'(UNITS));
    assign o_ok = (32'(o_reg) < 32'(UNITS));
    assign uidx = UIDX_W'(u_reg);
    assign oidx = UIDX_W'(o_reg);
    assign cur  = states_reg[uidx];

    // Sequencer and memory write control
    always_comb
    begin
        state_next  = state_reg;
        states_next = states_reg;
        mem_we      = 1'b0;
        mem_waddr   = {uidx, oidx};
        mem_wdata   = val_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (req_reg)
                    REQ_WEIGHT:
                    begin
                        if (u_ok && o_ok && (u_reg != o_reg))
                        begin
                            mem_we     = 1'b1;
                            state_next = S_WR_PAIR;
                        end
                    end
                    REQ_BIAS:
                    begin
                        mem_we    = u_ok;
                        mem_waddr = {uidx, uidx};
                    end
                    REQ_STATE:
                    begin
                        if (u_ok)
                        begin
                            states_next[uidx] = val_reg[0];
                        end
                    end
                    REQ_RESAMPLE:
                    begin
                        if (u_ok)
                        begin
                            state_next = S_ACC;
                        end
                    end
                endcase
            end
            S_WR_PAIR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {oidx, uidx};
                state_next = S_DONE;
            end
            S_ACC:
            begin
                if (col_reg == UIDX_W'(UNITS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_MUL;
            S_MUL:    state_next = S_PROB;
            S_PROB:   state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (flip)
                begin
                    states_next[uidx] = ~cur;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Coefficient memory
    bgs_coef_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (COEF_W)
    ) u_coef_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr ({uidx, col_reg}),
        .rdata (mem_rdata)
    );

    // Diagonal entry is the bias; off-diagonal entries count for active units
    assign add_en = (rd_col_reg == uidx) || states_reg[rd_col_reg];

    // Energy change magnitude and sign
    assign acc_neg = acc_reg[FIELD_W-1];
    assign mag     = acc_neg ? FIELD_W'(-acc_reg) : FIELD_W'(acc_reg);

    // Saturate, round to a quarter, look up the flip probability
    assign m_val   = prod_reg[PROD_W-1:FRAC_BITS];
    assign m_sat   = (m_val > M_W'(MAG_SAT)) ? MAG_SAT : m_val[MSAT_W-1:0];
    assign m_round = {1'b0, m_sat} + IDX_ROUND;
    assign tab_idx = m_round[MSAT_W-1:10];
    assign entry   = {1'b0, flip_entry(tab_idx)};
    assign p_val   = de_zero_reg ? PROB_HALF : (de_pos_reg ? entry : (PROB_ONE - entry));
    assign flip    = ({1'b0, rnd_reg} <= p_reg);

    assign states_pad = {{STATES_W{1'b0}}, states_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            col_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            states_reg    <= '0;
            out_valid_reg <= 1'b0;
            itemp_reg     <= ITEMP_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            states_reg <= states_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_EXEC)
            begin
                col_reg <= '0;
            end
            else if (state_reg == S_ACC)
            begin
                col_reg <= col_reg + 1'b1;
            end
            rd_pend_reg <= (state_reg == S_ACC);
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                itemp_reg <= cfg_data;
            end
        end
    end

    // Request latch and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type_t'(req_type);
            u_reg   <= unit_index;
            o_reg   <= other_index;
            val_reg <= value;
            rnd_reg <= random_fraction;
        end
        rd_col_reg <= col_reg;
        // local field accumulation, one coefficient per cycle
        if (state_reg == S_EXEC)
        begin
            acc_reg <= '0;
        end
        else if (rd_pend_reg && add_en)
        begin
            acc_reg <= acc_reg + FIELD_W'($signed(mem_rdata));
        end
        // scale by inverse temperature
        if (state_reg == S_MUL)
        begin
            prod_reg    <= PROD_W'(mag) * PROD_W'(itemp_reg);
            de_zero_reg <= (acc_reg == '0);
            de_pos_reg  <= cur ? (!acc_neg && (acc_reg != '0)) : acc_neg;
        end
        if (state_reg == S_PROB)
        begin
            p_reg <= p_val;
        end
        if (out_load)
        begin
            new_state_reg  <= u_ok ? states_reg[uidx] : 1'b0;
            all_states_reg <= states_pad[STATES_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_state  = new_state_reg;
    assign all_states = all_states_reg;

    // A result is only presented after the sequencer finished a request
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result presented without a finished request");

    // No memory write while the local field is being accumulated
    a_no_write_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC || state_reg == S_DRAIN) |-> !mem_we)
        else $error("coefficient write during accumulation");

    // Only one request in flight
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("second request taken while one is in flight");

    // Unit states change only on a state write or a resample decision
    a_state_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(states_reg) |-> $past(state_reg == S_EXEC || state_reg == S_DECIDE))
        else $error("unit states changed outside an update step");

endmodule
